// File: sv/stepper_pulse_position_controller_defines.svh
// ----------------------------------------------------------------------------
// Stepper pulse position controller: assertion macros
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STEPPER_PULSE_POSITION_CONTROLLER_DEFINES_SVH
`define STEPPER_PULSE_POSITION_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg
// Types, codes and constants of the stepper pulse position controller.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  localparam int POS_BITS = 32;
  localparam int CMP_BITS = (POS_BITS > 32) ? POS_BITS : 32;

  localparam int DIV_BITS  = 10;
  localparam int DIV_STEPS = DIV_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);
  localparam int VEL_BITS  = 16;

  localparam logic [DIV_BITS-1:0] DIVIDEND       = DIV_BITS'(1000);
  localparam logic [DIV_BITS-1:0] INTERVAL_RESET = DIV_BITS'(1000);

  localparam logic [2:0] MODE_STEP      = 3'd0;
  localparam logic [2:0] MODE_RUN       = 3'd1;
  localparam logic [2:0] MODE_GOAL_STEP = 3'd2;
  localparam logic [2:0] MODE_GOAL_RUN  = 3'd3;
  localparam logic [2:0] MODE_SET_VEL   = 3'd4;
  localparam logic [2:0] MODE_CLEAR     = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_COMPARE = 4'b0010,
    ST_DIVIDE  = 4'b0100,
    ST_UPDATE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// File: sv/spc_stream_if.sv
// ----------------------------------------------------------------------------
// spc_stream_if
// Command and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_cmd_if import spc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [2:0]                 mode;
  logic [31:0]                now_ms;
  logic signed [31:0]         goal_position;
  logic signed [VEL_BITS-1:0] velocity;
  logic                       limit_cw_hit;
  logic                       limit_ccw_hit;

  modport source (
    output valid, mode, now_ms, goal_position, velocity, limit_cw_hit, limit_ccw_hit,
    input  ready
  );

  modport sink (
    input  valid, mode, now_ms, goal_position, velocity, limit_cw_hit, limit_ccw_hit,
    output ready
  );
endinterface

interface spc_rsp_if;
  logic               valid;
  logic               ready;
  logic               step_pulse;
  logic               direction_cw;
  logic               at_goal;
  logic signed [31:0] position;

  modport source (
    output valid, step_pulse, direction_cw, at_goal, position,
    input  ready
  );

  modport sink (
    input  valid, step_pulse, direction_cw, at_goal, position,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/spc_divider.sv
// ----------------------------------------------------------------------------
// spc_divider
// Restoring divider, one quotient bit per cycle: interval = 1000 / divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_divider import spc_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [VEL_BITS-1:0] divisor,
  output div_status_t              status,
  output logic [DIV_BITS-1:0]      quotient
);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] dvd;
  logic [VEL_BITS-1:0] dsr;
  logic [DIV_BITS:0]   trial;
  logic [VEL_BITS-1:0] diff;
  logic                ge;

  always_comb begin
    trial = {rem, dvd[DIV_BITS-1]};
    ge    = VEL_BITS'(trial) >= dsr;
    diff  = VEL_BITS'(trial) - dsr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvd      <= DIVIDEND;
      dsr      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      dvd      <= {dvd[DIV_BITS-2:0], 1'b0};
      quotient <= {quotient[DIV_BITS-2:0], ge};
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

`default_nettype wire

// File: sv/stepper_pulse_position_controller.sv
// ----------------------------------------------------------------------------
// stepper_pulse_position_controller
// Step pulse generator with position tracking, goal seeking and limit checks.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transfer: mode, now_ms, goal_position,
//   velocity and the two limit flags. rsp returns exactly one result per
//   command: step_pulse, direction_cw, at_goal and position.
//   A command runs through a small sequencer: compare (goal, elapsed time,
//   limits), then, for set velocity with a nonzero velocity, divide in the
//   bit-serial 1000 / |velocity| divider, then update (position, last step
//   time, result register), which raises rsp.valid. The next command can
//   transfer in the cycle that the result is read; the block takes one
//   command at a time.
//   cmd.ready is high in idle while the result register is empty or being
//   read in the same cycle, so a stalled rsp holds its result and blocks cmd.
//   Reset (rst, synchronous) sets direction clockwise, position 0, last step
//   time 0, step interval 1000 ms and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_pulse_position_controller import spc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  spc_cmd_if.sink   cmd,
  spc_rsp_if.source rsp
);

`include "stepper_pulse_position_controller_defines.svh"

  state_t state;
  state_t state_next;

  logic [2:0]                 mode;
  logic [31:0]                now_ms;
  logic signed [31:0]         goal_position;
  logic signed [VEL_BITS-1:0] velocity;
  logic                       limit_cw_hit;
  logic                       limit_ccw_hit;

  logic                       direction_state;
  logic signed [POS_BITS-1:0] net_position;
  logic [31:0]                last_step_time;
  logic [DIV_BITS-1:0]        step_interval;

  logic step_go;
  logic at_goal;

  logic                       rsp_valid;
  logic                       rsp_step_pulse;
  logic                       rsp_direction_cw;
  logic                       rsp_at_goal;
  logic signed [31:0]         rsp_position;

  logic                       cmd_xfer;
  logic                       rsp_xfer;
  logic signed [CMP_BITS-1:0] pos_wide;
  logic signed [CMP_BITS-1:0] goal_wide;
  logic                       goal_mode;
  logic                       goal_eq;
  logic                       goal_lt;
  logic                       dir_next;
  logic                       blocked;
  logic                       run_mode;
  logic                       motion_mode;
  logic [31:0]                elapsed;
  logic                       fire;
  logic                       step_go_next;
  logic                       at_goal_next;
  logic                       div_start;
  logic [VEL_BITS-1:0]        vel_mag;
  logic signed [POS_BITS-1:0] pos_next;
  div_status_t                div_status;
  logic [DIV_BITS-1:0]        div_quotient;

  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign rsp_xfer  = rsp_valid && rsp.ready;
  assign cmd.ready = (state == ST_IDLE) && (!rsp_valid || rsp.ready);

  always_comb begin
    pos_wide     = CMP_BITS'(net_position);
    goal_wide    = CMP_BITS'(goal_position);
    goal_mode    = (mode == MODE_GOAL_STEP) || (mode == MODE_GOAL_RUN);
    goal_eq      = pos_wide == goal_wide;
    goal_lt      = pos_wide < goal_wide;
    dir_next     = (goal_mode && !goal_eq) ? goal_lt : direction_state;
    blocked      = dir_next ? limit_cw_hit : limit_ccw_hit;
    run_mode     = (mode == MODE_RUN) || (mode == MODE_GOAL_RUN);
    motion_mode  = (mode == MODE_STEP) || (mode == MODE_RUN) || goal_mode;
    elapsed      = now_ms - last_step_time;
    fire         = elapsed >= 32'(step_interval);
    at_goal_next = goal_mode && goal_eq;
    step_go_next = motion_mode && !at_goal_next && fire && !(run_mode && blocked);
    div_start    = (state == ST_COMPARE) && (mode == MODE_SET_VEL) && (velocity != '0);
    vel_mag      = velocity[VEL_BITS-1] ? (VEL_BITS'(0) - velocity) : velocity;
    pos_next     = net_position + {{(POS_BITS-1){~direction_state}}, 1'b1};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (cmd_xfer) state_next = ST_COMPARE;
      ST_COMPARE: state_next = div_start ? ST_DIVIDE : ST_UPDATE;
      ST_DIVIDE:  if (div_status.done) state_next = ST_UPDATE;
      ST_UPDATE:  state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      rsp_valid       <= 1'b0;
      direction_state <= 1'b1;
      net_position    <= '0;
      last_step_time  <= '0;
      step_interval   <= INTERVAL_RESET;
      step_go         <= 1'b0;
      at_goal         <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_xfer) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
        end
        ST_COMPARE: begin
          direction_state <= dir_next;
          step_go         <= step_go_next;
          at_goal         <= at_goal_next;
        end
        ST_DIVIDE: begin
          if (div_status.done) begin
            step_interval   <= div_quotient;
            direction_state <= ~velocity[VEL_BITS-1];
          end
        end
        ST_UPDATE: begin
          rsp_valid <= 1'b1;
          if (mode == MODE_CLEAR) begin
            net_position <= '0;
          end else if (step_go) begin
            net_position   <= pos_next;
            last_step_time <= last_step_time + 32'(step_interval);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      mode          <= cmd.mode;
      now_ms        <= cmd.now_ms;
      goal_position <= cmd.goal_position;
      velocity      <= cmd.velocity;
      limit_cw_hit  <= cmd.limit_cw_hit;
      limit_ccw_hit <= cmd.limit_ccw_hit;
    end
    if (state == ST_UPDATE) begin
      rsp_step_pulse   <= step_go;
      rsp_direction_cw <= direction_state;
      rsp_at_goal      <= at_goal;
      rsp_position     <= (mode == MODE_CLEAR) ? 32'sd0
                        : (step_go ? 32'(pos_next) : 32'(net_position));
    end
  end

  spc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (vel_mag),
    .status   (div_status),
    .quotient (div_quotient)
  );

  assign rsp.valid        = rsp_valid;
  assign rsp.step_pulse   = rsp_step_pulse;
  assign rsp.direction_cw = rsp_direction_cw;
  assign rsp.at_goal      = rsp_at_goal;
  assign rsp.position     = rsp_position;

  `SPC_ASSERT_NEXT(a_busy_after_xfer, clk, rst, cmd_xfer, !cmd.ready, "ready after transfer")
  `SPC_ASSERT_NOW(a_update_free, clk, rst, state == ST_UPDATE, !rsp_valid, "result overwrite")
  `SPC_ASSERT_NOW(a_div_in_divide, clk, rst, div_status.done, state == ST_DIVIDE, "stray divide")
  `SPC_ASSERT_NOW(a_pulse_goal, clk, rst, rsp_valid, !(rsp_step_pulse && rsp_at_goal), "step at goal")

endmodule

`default_nettype wire

// File: tb/stepper_pulse_position_controller_checker.sv
// ----------------------------------------------------------------------------
// stepper_pulse_position_controller_checker
// Watches the command and response channels, tracks direction, position,
// last step time and step interval for every command transfer, and compares
// each response transfer field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module stepper_pulse_position_controller_checker import spc_pkg::*; (
  input  logic clk,
  input  logic rst,
  spc_cmd_if   cmd,
  spc_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [16:0] MS_PER_SECOND = 17'd1000;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic               step_pulse;
    logic               direction_cw;
    logic               at_goal;
    logic signed [31:0] position;
  } motion_result_t;

  logic                dir_cw;
  logic signed [31:0]  net_pos;
  logic [31:0]         last_step_ms;
  logic [DIV_BITS-1:0] interval_ms;
  motion_result_t      expected_results[$];

  function automatic logic fire_step(logic [31:0] now);
    logic [31:0] elapsed;
    elapsed = now - last_step_ms;
    if (elapsed < 32'(interval_ms)) begin
      return 1'b0;
    end
    last_step_ms = last_step_ms + 32'(interval_ms);
    if (dir_cw) begin
      net_pos = net_pos + 32'sd1;
    end else begin
      net_pos = net_pos - 32'sd1;
    end
    return 1'b1;
  endfunction

  function automatic logic fire_run(logic [31:0] now, logic cw_hit, logic ccw_hit);
    if (dir_cw && cw_hit) begin
      return 1'b0;
    end
    if (!dir_cw && ccw_hit) begin
      return 1'b0;
    end
    return fire_step(now);
  endfunction

  function automatic motion_result_t predict_motion(
    logic [2:0]         mode,
    logic [31:0]        now,
    logic signed [31:0] goal,
    logic [15:0]        vel,
    logic               cw_hit,
    logic               ccw_hit
  );
    motion_result_t r;
    logic [16:0]    mag;
    r = '0;
    case (mode) inside
      MODE_STEP: begin
        r.step_pulse = fire_step(now);
      end
      MODE_RUN: begin
        r.step_pulse = fire_run(now, cw_hit, ccw_hit);
      end
      MODE_GOAL_STEP, MODE_GOAL_RUN: begin
        if (net_pos == goal) begin
          r.at_goal = 1'b1;
        end else begin
          dir_cw = (net_pos < goal);
          if (mode == MODE_GOAL_STEP) begin
            r.step_pulse = fire_step(now);
          end else begin
            r.step_pulse = fire_run(now, cw_hit, ccw_hit);
          end
        end
      end
      MODE_SET_VEL: begin
        if (vel != 16'd0) begin
          mag         = vel[15] ? (17'h10000 - {1'b0, vel}) : {1'b0, vel};
          dir_cw      = ~vel[15];
          interval_ms = DIV_BITS'(MS_PER_SECOND / mag);
        end
      end
      MODE_CLEAR: begin
        net_pos = '0;
      end
      default: begin
      end
    endcase
    r.direction_cw = dir_cw;
    r.position     = net_pos;
    return r;
  endfunction

  always @(posedge clk) begin
    motion_result_t seen;
    motion_result_t want;
    if (rst) begin
      dir_cw       = 1'b1;
      net_pos      = '0;
      last_step_ms = '0;
      interval_ms  = DIV_BITS'(1000);
      expected_results.delete();
    end else begin
      if (cmd.valid && cmd.ready) begin
        expected_results.push_back(predict_motion(cmd.mode, cmd.now_ms, cmd.goal_position,
                                                  cmd.velocity, cmd.limit_cw_hit,
                                                  cmd.limit_ccw_hit));
      end
      if (rsp.valid && rsp.ready) begin
        seen = '{rsp.step_pulse, rsp.direction_cw, rsp.at_goal, rsp.position};
        if (expected_results.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("%0t: unexpected response pulse=%0b dir=%0b at_goal=%0b pos=%0d",
                     $realtime, seen.step_pulse, seen.direction_cw, seen.at_goal,
                     seen.position);
          end
          mismatches = mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (seen.step_pulse !== want.step_pulse || seen.direction_cw !== want.direction_cw ||
              seen.at_goal !== want.at_goal || seen.position !== want.position) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("%0t: mismatch expected pulse=%0b dir=%0b at_goal=%0b pos=%0d",
                       $realtime, want.step_pulse, want.direction_cw, want.at_goal,
                       want.position);
              $display("%0t:          actual   pulse=%0b dir=%0b at_goal=%0b pos=%0d",
                       $realtime, seen.step_pulse, seen.direction_cw, seen.at_goal,
                       seen.position);
            end
            mismatches = mismatches + 1;
          end
        end
      end
    end
    outstanding <= expected_results.size();
  end

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

endmodule

// File: tb/stepper_pulse_position_controller_tb.sv
// ----------------------------------------------------------------------------
// stepper_pulse_position_controller_tb
// Drives directed and random motor commands under three pacing phases on the
// command and response channels, including a long response hold-off that
// backs up the command channel, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module stepper_pulse_position_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spc_pkg::*;

  localparam int         RANDOM_ITEMS   = 1300;
  localparam int         CYCLE_LIMIT    = 500000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         BACKLOG_CYCLES = 400;
  localparam logic [2:0] MODE_SPARE_A   = 3'd6;
  localparam logic [2:0] MODE_SPARE_B   = 3'd7;

  logic        clk;
  logic        rst;
  int          pace_phase;
  logic        backlog_done;
  logic [31:0] clock_ms;
  int          mismatches;
  int          outstanding;
  int          cycle_count;

  spc_cmd_if cmd_ch ();
  spc_rsp_if rsp_ch ();

  stepper_pulse_position_controller i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  stepper_pulse_position_controller_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int tx_idle_pct();
    case (pace_phase)
      0: return 16;
      1: return 70;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct();
    case (pace_phase)
      0: return 70;
      1: return 16;
      default: return 0;
    endcase
  endfunction

  task automatic offer_command(
    logic [2:0]         mode,
    logic [31:0]        now,
    logic signed [31:0] goal,
    logic signed [15:0] vel,
    logic               cw_hit,
    logic               ccw_hit
  );
    while ($urandom_range(99) < tx_idle_pct()) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid         <= 1'b1;
    cmd_ch.mode          <= mode;
    cmd_ch.now_ms        <= now;
    cmd_ch.goal_position <= goal;
    cmd_ch.velocity      <= vel;
    cmd_ch.limit_cw_hit  <= cw_hit;
    cmd_ch.limit_ccw_hit <= ccw_hit;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic offer_random_command();
    logic [2:0]         mode;
    logic signed [31:0] goal;
    logic signed [15:0] vel;
    int                 roll;
    int                 mag;
    roll = $urandom_range(99);
    if (roll < 20) begin
      mode = MODE_STEP;
    end else if (roll < 40) begin
      mode = MODE_RUN;
    end else if (roll < 55) begin
      mode = MODE_GOAL_STEP;
    end else if (roll < 70) begin
      mode = MODE_GOAL_RUN;
    end else if (roll < 87) begin
      mode = MODE_SET_VEL;
    end else if (roll < 95) begin
      mode = MODE_CLEAR;
    end else begin
      mode = roll[0] ? MODE_SPARE_A : MODE_SPARE_B;
    end
    roll = $urandom_range(99);
    if (roll < 70) begin
      clock_ms = clock_ms + $urandom_range(0, 25);
    end else if (roll < 95) begin
      clock_ms = clock_ms + $urandom_range(0, 1500);
    end else begin
      clock_ms = $urandom();
    end
    if ($urandom_range(99) < 80) begin
      goal = int'($urandom_range(0, 60)) - 30;
    end else begin
      goal = $urandom();
    end
    roll = $urandom_range(99);
    if (roll < 80) begin
      mag = (roll < 60) ? $urandom_range(40, 1200) : $urandom_range(1, 39);
      vel = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
    end else begin
      vel = 16'($urandom());
    end
    offer_command(mode, clock_ms, goal, vel, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 3) == 0);
  endtask

  initial begin
    rsp_ch.ready <= 1'b0;
    backlog_done = 1'b0;
    forever begin
      @(posedge clk);
      if (pace_phase == 2 && !backlog_done) begin
        backlog_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct());
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count = cycle_count + 1;
    end
    $display("stepper_pulse_position_controller_tb: FAIL");
    $finish;
  end

  initial begin
    pace_phase = 0;
    clock_ms   = '0;
    rst                  <= 1'b1;
    cmd_ch.valid         <= 1'b0;
    cmd_ch.mode          <= MODE_STEP;
    cmd_ch.now_ms        <= '0;
    cmd_ch.goal_position <= '0;
    cmd_ch.velocity      <= '0;
    cmd_ch.limit_cw_hit  <= 1'b0;
    cmd_ch.limit_ccw_hit <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    offer_command(MODE_STEP,      32'd0,          32'sd0, 16'sd0,     1'b0, 1'b0);
    offer_command(MODE_STEP,      32'd1000,       32'sd0, 16'sd0,     1'b0, 1'b0);
    offer_command(MODE_STEP,      32'hFFFF_FFFF,  32'sd0, 16'sd0,     1'b0, 1'b0);
    offer_command(MODE_RUN,       32'd3000,       32'sd0, 16'sd0,     1'b1, 1'b0);
    offer_command(MODE_RUN,       32'd3000,       32'sd0, 16'sd0,     1'b0, 1'b1);
    offer_command(MODE_SET_VEL,   32'd3000,       32'sd0, 16'sd0,     1'b0, 1'b0);
    offer_command(MODE_SET_VEL,   32'd3000,       32'sd0, -16'sd1,    1'b0, 1'b0);
    offer_command(MODE_RUN,       32'd4000,       32'sd0, 16'sd0,     1'b0, 1'b1);
    offer_command(MODE_SET_VEL,   32'd4000,       32'sd0, 16'sh7FFF,  1'b0, 1'b0);
    offer_command(MODE_STEP,      32'd4000,       32'sd0, 16'sd0,     1'b0, 1'b0);
    offer_command(MODE_SET_VEL,   32'd4000,       32'sd0, 16'sh8000,  1'b0, 1'b0);
    offer_command(MODE_STEP,      32'd4000,       32'sd0, 16'sd0,     1'b0, 1'b0);
    offer_command(MODE_SPARE_A,   32'hFFFF_FFFF,  -32'sd1, -16'sd1,   1'b1, 1'b1);
    offer_command(MODE_SPARE_B,   32'hFFFF_FFFF,  -32'sd1, -16'sd1,   1'b1, 1'b1);
    offer_command(MODE_CLEAR,     32'd4000,       32'sd0, 16'sd0,     1'b0, 1'b0);
    offer_command(MODE_GOAL_STEP, 32'd4000,       32'sd0, 16'sd0,     1'b0, 1'b0);
    offer_command(MODE_GOAL_RUN,  32'd4000,       32'sd3, 16'sd0,     1'b1, 1'b0);
    offer_command(MODE_GOAL_RUN,  32'd4000,       -32'sd2, 16'sd0,    1'b1, 1'b0);
    offer_command(MODE_GOAL_STEP, 32'd4001,       32'sh7FFF_FFFF, 16'sd0, 1'b0, 1'b0);
    offer_command(MODE_GOAL_STEP, 32'd4002,       32'sh8000_0000, 16'sd0, 1'b0, 1'b0);
    offer_command(MODE_SET_VEL,   32'd4002,       32'sd0, 16'sd1000,  1'b0, 1'b0);
    offer_command(MODE_SET_VEL,   32'd4002,       32'sd0, 16'sd1001,  1'b0, 1'b0);
    offer_command(MODE_SET_VEL,   32'd4002,       32'sd0, -16'sd500,  1'b0, 1'b0);
    offer_command(MODE_SET_VEL,   32'd4002,       32'sd0, 16'sd1,     1'b0, 1'b0);
    offer_command(MODE_CLEAR,     32'd4002,       32'sd0, 16'sd0,     1'b0, 1'b0);
    clock_ms = 32'd4002;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pace_phase = (i * 3) / RANDOM_ITEMS;
      offer_random_command();
    end
    cmd_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("stepper_pulse_position_controller_tb: PASS");
    end else begin
      $display("stepper_pulse_position_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
